>>> hw/rtl/cuckoo_fingerprint_table_defines.svh
// assertion macros for the cuckoo fingerprint table checker
`ifndef CUCKOO_FINGERPRINT_TABLE_DEFINES_SVH
`define CUCKOO_FINGERPRINT_TABLE_DEFINES_SVH

// same-cycle implication, off during reset
`define CFT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cft check failed");

// next-cycle implication, off during reset
`define CFT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cft check failed");

// next-cycle implication, also checked across reset
`define CFT_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cft reset check failed");

`endif

>>> hw/rtl/cft_pkg.sv
// shared types and constants of the cuckoo fingerprint table
package cft_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int KICK_LIMIT_DEF  = 16;
  localparam int LOOKUP_PROBES   = 2;
  localparam int SIZE_W          = 11;
  localparam int KEY_W           = 64;
  localparam int COUNT_W         = 11;
  localparam int EVSLOT_W        = 10;
  localparam int MOD_BITS        = 4;
  localparam int MOD_STEPS       = KEY_W / MOD_BITS;
  localparam int IN_DATA_W       = 128;
  localparam int OUT_DATA_W      = 88;
  localparam logic [SIZE_W-1:0]  SIZE_RESET = 11'd1024;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 11'd2047;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } state_t;

endpackage

>>> hw/rtl/cuckoo_fingerprint_table.sv
// cuckoo fingerprint table: insert, remove and lookup over a slot memory
//
//  channel  dir  ports                          word
//  s        in   s_tvalid s_tready s_tdata      kind in tuser, index_hash, fingerprint
//           in   s_tuser
//  m        out  m_tvalid m_tready m_tdata      hit, overflow, slot, fingerprint, count
//  cfg      in   cfg_wen cfg_wdata              table_size
//
//  each probe: a pass of the shared 4-bit-per-cycle remainder unit, then a
//  memory read and an evaluate step
//  an item runs up to KICK_LIMIT+1 remainders on insert
//  after reset a clearing pass writes zero to all TABLE_DEPTH slots, one a cycle
//  s_tready is high only when idle; a finished word waits in the output register
module cuckoo_fingerprint_table #(
  parameter int TABLE_DEPTH = cft_pkg::TABLE_DEPTH_DEF,
  parameter int KICK_LIMIT  = cft_pkg::KICK_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // index_hash [63:0], fingerprint [127:64]
  input  logic [cft_pkg::IN_DATA_W-1:0]  s_tdata,
  // kind [1:0]
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // hit [0], overflow [1], evicted_slot [11:2], evicted_fingerprint [75:12],
  // entry_count [86:76], zero [87]
  output logic [cft_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           cfg_wen,
  input  logic [cft_pkg::SIZE_W-1:0]     cfg_wdata
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TW = $clog2(KICK_LIMIT + cft_pkg::LOOKUP_PROBES + 1);
  localparam int MW = $clog2(cft_pkg::MOD_STEPS);
  localparam int SW = cft_pkg::SIZE_W;
  localparam int KW = cft_pkg::KEY_W;

  cft_pkg::state_t state, state_next;
  cft_pkg::op_t    op;

  logic [SW-1:0]               table_size;
  logic [SW-1:0]               divisor;
  logic [SW-1:0]               rem;
  logic [SW-1:0]               rem_next;
  logic [KW-1:0]               dvd;
  logic [MW-1:0]               mod_cnt;
  logic [KW-1:0]               fp;
  logic [AW-1:0]               slot;
  logic [AW-1:0]               clr_addr;
  logic [TW-1:0]               tries;
  logic [cft_pkg::COUNT_W-1:0] count;
  logic                        hit;
  logic                        ovf;
  logic [KW-1:0]               mem [TABLE_DEPTH];
  logic [KW-1:0]               rdata;

  logic                        mem_we;
  logic [AW-1:0]               mem_wa;
  logic [KW-1:0]               mem_wd;
  logic                        eval_done;
  logic                        eval_hit;
  logic                        eval_ovf;
  logic                        eval_cnt;
  logic [KW-1:0]               eval_fp;
  logic                        s_acc;
  logic                        out_free;
  logic                        acc_skip;
  logic [SW-1:0]               eff_size;
  logic                        match;
  logic                        empty;
  logic [TW-1:0]               tries_inc;

  assign s_tready = (state == cft_pkg::ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign acc_skip = (cft_pkg::op_t'(s_tuser) == cft_pkg::OP_NONE) ||
                    ((cft_pkg::op_t'(s_tuser) == cft_pkg::OP_LOOKUP) &&
                     (s_tdata[2*KW-1:KW] == '0));
  assign match     = (rdata == fp);
  assign empty     = (rdata == '0);
  assign tries_inc = tries + TW'(1);

  always_comb begin
    if (table_size == '0) begin
      eff_size = SW'(1);
    end else if (32'(table_size) > TABLE_DEPTH) begin
      eff_size = SW'(TABLE_DEPTH);
    end else begin
      eff_size = table_size;
    end
  end

  // remainder unit, MOD_BITS dividend bits a cycle
  always_comb begin
    logic [SW:0] t;
    t = '0;
    rem_next = rem;
    for (int j = 0; j < cft_pkg::MOD_BITS; j++) begin
      t = {rem_next, dvd[KW-1-j]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      rem_next = t[SW-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cft_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(TABLE_DEPTH - 1)) state_next = cft_pkg::ST_IDLE;
      end
      cft_pkg::ST_IDLE: begin
        if (s_acc) state_next = acc_skip ? cft_pkg::ST_DONE : cft_pkg::ST_MOD;
      end
      cft_pkg::ST_MOD: begin
        if (mod_cnt == MW'(cft_pkg::MOD_STEPS - 1)) begin
          state_next = ovf ? cft_pkg::ST_DONE : cft_pkg::ST_READ;
        end
      end
      cft_pkg::ST_READ: state_next = cft_pkg::ST_EVAL;
      cft_pkg::ST_EVAL: state_next = eval_done ? cft_pkg::ST_DONE : cft_pkg::ST_MOD;
      cft_pkg::ST_DONE: begin
        if (out_free) state_next = cft_pkg::ST_IDLE;
      end
      default: state_next = cft_pkg::ST_IDLE;
    endcase
  end

  // evaluate and memory write controls
  always_comb begin
    mem_we    = 1'b0;
    mem_wa    = slot;
    mem_wd    = '0;
    eval_done = 1'b0;
    eval_hit  = 1'b0;
    eval_ovf  = 1'b0;
    eval_cnt  = 1'b0;
    eval_fp   = fp;
    unique case (state)
      cft_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
      end
      cft_pkg::ST_EVAL: begin
        priority case (op)
          cft_pkg::OP_INSERT: begin
            if (match) begin
              eval_done = 1'b1;
            end else begin
              mem_we  = 1'b1;
              mem_wd  = fp;
              eval_fp = rdata;
              if (empty) begin
                eval_cnt  = 1'b1;
                eval_done = 1'b1;
              end else if (tries_inc == TW'(KICK_LIMIT)) begin
                eval_ovf = 1'b1;
              end
            end
          end
          cft_pkg::OP_REMOVE: begin
            if (empty) begin
              eval_done = 1'b1;
            end else if (match) begin
              mem_we    = 1'b1;
              eval_hit  = 1'b1;
              eval_done = 1'b1;
            end else if (tries_inc == TW'(KICK_LIMIT)) begin
              eval_done = 1'b1;
            end
          end
          default: begin
            if (match) begin
              eval_hit  = 1'b1;
              eval_done = 1'b1;
            end else if (tries_inc == TW'(cft_pkg::LOOKUP_PROBES)) begin
              eval_done = 1'b1;
            end
          end
        endcase
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata <= mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cft_pkg::ST_CLEAR;
      clr_addr   <= '0;
      table_size <= cft_pkg::SIZE_RESET;
      count      <= '0;
      m_tvalid   <= 1'b0;
      tries      <= '0;
      mod_cnt    <= '0;
      hit        <= 1'b0;
      ovf        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) table_size <= cfg_wdata;
      if (state == cft_pkg::ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if ((state == cft_pkg::ST_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        cft_pkg::ST_IDLE: begin
          if (s_acc) begin
            op      <= cft_pkg::op_t'(s_tuser);
            fp      <= s_tdata[2*KW-1:KW];
            dvd     <= s_tdata[KW-1:0];
            divisor <= eff_size;
            rem     <= '0;
            mod_cnt <= '0;
            tries   <= '0;
            hit     <= 1'b0;
            ovf     <= 1'b0;
            slot    <= '0;
          end
        end
        cft_pkg::ST_MOD: begin
          rem     <= rem_next;
          dvd     <= dvd << cft_pkg::MOD_BITS;
          mod_cnt <= mod_cnt + MW'(1);
          if (mod_cnt == MW'(cft_pkg::MOD_STEPS - 1)) slot <= AW'(rem_next);
        end
        cft_pkg::ST_EVAL: begin
          tries   <= tries_inc;
          hit     <= eval_hit;
          ovf     <= eval_ovf;
          fp      <= eval_fp;
          dvd     <= KW'(slot) ^ eval_fp;
          rem     <= '0;
          mod_cnt <= '0;
          if (eval_cnt && count != cft_pkg::COUNT_MAX) count <= count + 1'b1;
        end
        cft_pkg::ST_DONE: begin
          if (out_free) begin
            m_tdata  <= {1'b0, count, ovf ? fp : '0,
                         ovf ? cft_pkg::EVSLOT_W'(slot) : '0, ovf, hit};
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/cft_checker.sv
// port checker for the cuckoo fingerprint table, bound to the top level
`include "cuckoo_fingerprint_table_defines.svh"

module cft_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [cft_pkg::OUT_DATA_W-1:0] m_tdata
);

  `CFT_ASSERT_RST(a_rst_no_word, rst, !m_tvalid)
  `CFT_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `CFT_ASSERT_IMP(a_hit_ovf_excl, m_tvalid, !(m_tdata[0] && m_tdata[1]))
  `CFT_ASSERT_IMP(a_evict_zero, m_tvalid && !m_tdata[1], m_tdata[75:2] == '0)
  `CFT_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind cuckoo_fingerprint_table cft_checker u_cft_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> tb/tb_top.sv
// self-checking testbench for the cuckoo fingerprint table
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic        hit;
    logic        overflow;
    logic [9:0]  ev_slot;
    logic [63:0] ev_fp;
    logic [10:0] count;
  } verdict_t;

  typedef struct {
    cft_pkg::op_t op;
    logic [63:0]  idx;
    logic [63:0]  fp;
    bit           typed;
    verdict_t     res;
  } row_t;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [cft_pkg::IN_DATA_W-1:0]  s_tdata;
  logic [1:0]                     s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [cft_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           cfg_wen;
  logic [cft_pkg::SIZE_W-1:0]     cfg_wdata;

  logic [63:0] shadow_slots [cft_pkg::TABLE_DEPTH_DEF];
  logic [10:0] shadow_count;
  logic [10:0] shadow_size;
  verdict_t    pending_words [$];
  logic [63:0] pool_idx [$];
  logic [63:0] pool_fp [$];
  int          errors = 0;
  bit          quiet = 0;
  int          m_stall = 0;

  cuckoo_fingerprint_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("cuckoo_fingerprint_table regression: fail");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // walks the probe chain on the shadow table and returns the expected word
  task automatic predict_table(input cft_pkg::op_t op, input logic [63:0] idx,
                               input logic [63:0] fp_in, output verdict_t res);
    logic [63:0] size;
    logic [63:0] slot;
    logic [63:0] fp;
    logic [63:0] old;
    bit          done;
    size = (shadow_size == 0) ? 64'd1 :
           (shadow_size > cft_pkg::TABLE_DEPTH_DEF) ? 64'(cft_pkg::TABLE_DEPTH_DEF) :
           64'(shadow_size);
    fp   = fp_in;
    slot = idx % size;
    done = 0;
    res  = '0;
    case (op)
      cft_pkg::OP_INSERT: begin
        for (int i = 0; i < cft_pkg::KICK_LIMIT_DEF && !done; i++) begin
          old = shadow_slots[slot];
          if (old == fp) begin
            done = 1;
          end else begin
            shadow_slots[slot] = fp;
            fp = old;
            if (old == 0) begin
              if (shadow_count != cft_pkg::COUNT_MAX) shadow_count++;
              done = 1;
            end else begin
              slot = (slot ^ fp) % size;
            end
          end
        end
        if (!done) begin
          res.overflow = 1;
          res.ev_slot  = slot[9:0];
          res.ev_fp    = fp;
        end
      end
      cft_pkg::OP_REMOVE: begin
        for (int i = 0; i < cft_pkg::KICK_LIMIT_DEF && !done; i++) begin
          old = shadow_slots[slot];
          if (old == 0) begin
            done = 1;
          end else if (old == fp) begin
            shadow_slots[slot] = 0;
            res.hit = 1;
            done = 1;
          end else begin
            slot = (slot ^ fp) % size;
          end
        end
      end
      cft_pkg::OP_LOOKUP: begin
        if (fp != 0) begin
          for (int i = 0; i < cft_pkg::LOOKUP_PROBES && !done; i++) begin
            if (shadow_slots[slot] == fp) begin
              res.hit = 1;
              done = 1;
            end
            slot = (slot ^ fp) % size;
          end
        end
      end
      default: ;
    endcase
    res.count = shadow_count;
  endtask

  task automatic send_word(input cft_pkg::op_t op, input logic [63:0] idx,
                           input logic [63:0] fp, input bit typed, input verdict_t typed_res);
    verdict_t res;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {fp, idx};
    do @(posedge clk); while (!s_tready);
    predict_table(op, idx, fp, res);
    pending_words.push_back(typed ? typed_res : res);
    if (op == cft_pkg::OP_INSERT && fp != 0) begin
      pool_idx.push_back(idx);
      pool_fp.push_back(fp);
      if (pool_idx.size() > 64) begin
        void'(pool_idx.pop_front());
        void'(pool_fp.pop_front());
      end
    end
  endtask

  task automatic sender_gap();
    int n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 5);
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // drains all results, then writes the size register while the block is idle
  task automatic set_size(input logic [10:0] value);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    cfg_wen     <= 1'b1;
    cfg_wdata   <= value;
    shadow_size = value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst || quiet) begin
      m_tready <= 1'b1;
      m_stall  <= 0;
    end else if (m_stall > 0) begin
      m_tready <= 1'b0;
      m_stall  <= m_stall - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      m_stall  <= $urandom_range(0, 4);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.hit      = m_tdata[0];
      got.overflow = m_tdata[1];
      got.ev_slot  = m_tdata[11:2];
      got.ev_fp    = m_tdata[75:12];
      got.count    = m_tdata[86:76];
      if (pending_words.size() == 0) begin
        report("unexpected word", 64'(got.count), 64'd0);
      end else begin
        want = pending_words.pop_front();
        if (got.hit !== want.hit) report("hit", 64'(got.hit), 64'(want.hit));
        if (got.overflow !== want.overflow)
          report("overflow", 64'(got.overflow), 64'(want.overflow));
        if (got.ev_slot !== want.ev_slot)
          report("evicted_slot", 64'(got.ev_slot), 64'(want.ev_slot));
        if (got.ev_fp !== want.ev_fp) report("evicted_fingerprint", got.ev_fp, want.ev_fp);
        if (got.count !== want.count)
          report("entry_count", 64'(got.count), 64'(want.count));
      end
    end
  end

  row_t directed [] = '{
    '{cft_pkg::OP_LOOKUP, 64'd0, 64'd5, 1, '{0, 0, 0, 0, 0}},
    '{cft_pkg::OP_INSERT, 64'd0, 64'd0, 1, '{0, 0, 0, 0, 0}},
    '{cft_pkg::OP_REMOVE, 64'd0, 64'd0, 1, '{0, 0, 0, 0, 0}},
    '{cft_pkg::OP_NONE,   64'd0, 64'd7, 1, '{0, 0, 0, 0, 0}},
    '{cft_pkg::OP_INSERT, 64'd0, 64'd5, 1, '{0, 0, 0, 0, 1}},
    '{cft_pkg::OP_LOOKUP, 64'd0, 64'd5, 1, '{1, 0, 0, 0, 1}},
    '{cft_pkg::OP_INSERT, 64'd0, 64'd5, 1, '{0, 0, 0, 0, 1}},
    '{cft_pkg::OP_LOOKUP, 64'd0, 64'd0, 1, '{0, 0, 0, 0, 1}},
    '{cft_pkg::OP_INSERT, '1, '1, 0, '0},
    '{cft_pkg::OP_LOOKUP, '1, '1, 0, '0},
    '{cft_pkg::OP_REMOVE, 64'd0, 64'd5, 1, '{1, 0, 0, 0, 2}},
    '{cft_pkg::OP_REMOVE, 64'd0, 64'd5, 1, '{0, 0, 0, 0, 2}},
    '{cft_pkg::OP_INSERT, 64'd1024, 64'h400, 0, '0},
    '{cft_pkg::OP_INSERT, 64'd1024, 64'h8000_0000_0000_0001, 0, '0},
    '{cft_pkg::OP_LOOKUP, 64'd1024, 64'h8000_0000_0000_0001, 0, '0},
    '{cft_pkg::OP_REMOVE, '1, '1, 0, '0},
    '{cft_pkg::OP_NONE,   '1, '1, 0, '0}
  };

  logic [10:0] sizes [] = '{11'd1024, 11'd0, 11'd1, 11'd2, 11'd7, 11'd2047, 11'd64, 11'd300};

  initial begin
    int           pick;
    int           r;
    logic [63:0]  idx;
    logic [63:0]  fp;
    cft_pkg::op_t op;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_wen   = 1'b0;
    cfg_wdata = '0;
    m_tready  = 1'b1;
    foreach (shadow_slots[i]) shadow_slots[i] = '0;
    shadow_count = 0;
    shadow_size  = cft_pkg::SIZE_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      send_word(directed[i].op, directed[i].idx, directed[i].fp,
                directed[i].typed, directed[i].res);
      sender_gap();
    end

    foreach (sizes[p]) begin
      set_size(sizes[p]);
      if (p == sizes.size() - 1) quiet = 1;
      for (int n = 0; n < 225; n++) begin
        r  = $urandom_range(0, 99);
        fp = rand64();
        idx = rand64();
        if (r < 10) fp = 64'($urandom_range(1, 15));
        if (r < 45) begin
          op = cft_pkg::OP_INSERT;
        end else if (r < 85 && pool_fp.size() != 0) begin
          pick = $urandom_range(0, pool_fp.size() - 1);
          idx  = pool_idx[pick];
          fp   = pool_fp[pick];
          op   = (r < 65) ? cft_pkg::OP_LOOKUP : cft_pkg::OP_REMOVE;
        end else if (r < 92) begin
          op = cft_pkg::OP_LOOKUP;
        end else if (r < 97) begin
          op = cft_pkg::OP_REMOVE;
        end else begin
          op = cft_pkg::op_t'($urandom_range(0, 3));
          if (r == 99) fp = '0;
        end
        send_word(op, idx, fp, 0, '0);
        sender_gap();
      end
    end

    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0)
      $display("cuckoo_fingerprint_table regression: pass");
    else
      $display("cuckoo_fingerprint_table regression: fail");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/cft_pkg.sv
hw/rtl/cuckoo_fingerprint_table.sv
hw/rtl/cft_checker.sv
tb/tb_top.sv
